/* rtl/rgb_colour_temperature_and_lux_macros.svh */
// assertion macros shared by the colour temperature rtl
`ifndef RGB_COLOUR_TEMPERATURE_AND_LUX_MACROS_SVH
`define RGB_COLOUR_TEMPERATURE_AND_LUX_MACROS_SVH

// same-cycle implication, disabled during reset
`define RGBCT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgbct check failed");

// next-cycle implication, disabled during reset
`define RGBCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rgbct check failed");

`endif

/* rtl/rgbct_pkg.sv */
// shared types and constants of the colour temperature and lux block
`timescale 1ns / 1ps
package rgbct_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam logic [15:0] SAMPLE_MASK = 16'((17'd1 << SAMPLE_BITS) - 17'd1);

    localparam int Q_FRAC = 16;
    localparam int COEF_W = 18;
    localparam int SMP_W  = 17;
    localparam int PROD_W = COEF_W + SMP_W;
    localparam int ROW_W  = PROD_W + 1;

    // divider sizing
    localparam int NUM_W   = 50;
    localparam int DEN_W   = 35;
    localparam int QUO_W   = 25;
    localparam int DIV_LAT = QUO_W + 1;

    // request to strobe, counted in clock edges
    localparam int PIPE_DEPTH = 2 * DIV_LAT + 10;

    localparam int XY_W = 18;
    localparam int XY_POS_LIM = 131071;
    localparam int XY_NEG_LIM = 131072;
    localparam int N_W = 25;
    localparam int N_POS_LIM = 16777215;
    localparam int N_NEG_LIM = 16777216;

    localparam int LUX_W = 21;
    localparam int LUX_MAX = 2097151;

    localparam int A_W  = 35;
    localparam int P1_W = A_W + N_W;
    localparam int BS_W = 46;
    localparam int B_W  = 40;
    localparam int P2_W = B_W + N_W;
    localparam int C_W  = 50;

    localparam logic signed [XY_W:0] X_REF = 19'sd21758;
    localparam logic signed [XY_W:0] Y_REF = 19'sd12177;
    localparam logic signed [A_W-1:0] A_OFF = 35'sd231014400;
    localparam logic signed [BS_W-1:0] B_OFF = 46'sd447171789;
    localparam logic signed [BS_W-1:0] B_LIM = 46'sd274877906944;
    localparam logic signed [C_W-1:0] C_OFF = 50'sd361780347;
    localparam logic signed [A_W-1:0] K_CUBE = 35'sd449;

    localparam logic signed [COEF_W-1:0] COEF [3][3] = '{
        '{-18'sd9360,  18'sd101531, -18'sd62679},
        '{-18'sd21277, 18'sd103440, -18'sd47966},
        '{-18'sd44697, 18'sd50511,   18'sd36918}
    };

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_CLEAR_ZERO = 2'd1,
        ST_ZERO_DEN   = 2'd2,
        ST_CCT_SAT    = 2'd3
    } t_status;

    typedef struct packed {
        logic             valid;
        logic             clr_zero;
        logic             den_zero;
        logic [LUX_W-1:0] lux;
    } t_side;

endpackage

/* rtl/rgbct_div.sv */
// pipelined restoring divider, one quotient bit per stage, magnitude in and out
`timescale 1ns / 1ps
module rgbct_div (
    input  logic                        i_clk,
    input  logic [rgbct_pkg::NUM_W-1:0] i_num,
    input  logic [rgbct_pkg::DEN_W-1:0] i_den,
    input  logic                        i_neg,
    output logic [rgbct_pkg::QUO_W-1:0] o_quo,
    output logic                        o_ovf,
    output logic                        o_neg
);
    import rgbct_pkg::*;

    localparam int SH_W = DEN_W + QUO_W;

    logic [NUM_W-1:0] r_rem [0:QUO_W];
    logic [DEN_W-1:0] r_den [0:QUO_W];
    logic [QUO_W-1:0] r_quo [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic             r_neg [0:QUO_W];

    logic [NUM_W-1:0] n_rem [1:QUO_W];
    logic [QUO_W-1:0] n_quo [1:QUO_W];

    always_comb begin
        logic [SH_W-1:0] sh;
        for (int k = 1; k <= QUO_W; k++) begin
            sh = SH_W'(r_den[k-1]) << (QUO_W - k);
            n_rem[k] = r_rem[k-1];
            n_quo[k] = r_quo[k-1];
            if (SH_W'(r_rem[k-1]) >= sh) begin
                n_rem[k] = r_rem[k-1] - NUM_W'(sh);
                n_quo[k][QUO_W-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // entry: quotient beyond QUO_W bits is flagged once here
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_ovf[0] <= (DEN_W'(i_num >> QUO_W) >= i_den);
        r_neg[0] <= i_neg;
        for (int k = 1; k <= QUO_W; k++) begin
            r_rem[k] <= n_rem[k];
            r_den[k] <= r_den[k-1];
            r_quo[k] <= n_quo[k];
            r_ovf[k] <= r_ovf[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    assign o_quo = r_quo[QUO_W];
    assign o_ovf = r_ovf[QUO_W];
    assign o_neg = r_neg[QUO_W];

endmodule

/* rtl/rgb_colour_temperature_and_lux.sv */
// top level: colour temperature and illuminance from one colour-sensor sample
//
// usage: drive i_red, i_green, i_blue, i_clear and pulse start; a request is
// taken at any rising edge with start high and busy low. busy never rises,
// so a new request may be issued in every cycle (one sample per clock).
// each result (o_cct_kelvin, o_lux_q4, o_status) appears for exactly one
// cycle with o_strobe high, in request order; there are 62 register
// stages from request to strobe.
// latency is set by the two chained 26-stage dividers (chromaticity x/y,
// then the mccamy ratio n), each retiring one quotient bit per stage, plus
// three front stages (matrix products, row sums, xyz sum), one stage for
// the n operands and five for the cubic (saturate n, a, a*n, b, b*n) and
// the output register.
// reset (synchronous, active low) clears every valid bit in the pipeline;
// requests in flight are dropped. the receiver has no hold-off, so there
// is no stall path: every stage advances in every cycle.
// status: 0 ok, 1 clear channel zero, 2 zero denominator, 3 cct saturated.
`timescale 1ns / 1ps
`include "rgb_colour_temperature_and_lux_macros.svh"
module rgb_colour_temperature_and_lux (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [15:0]                 i_red,
    input  logic [15:0]                 i_green,
    input  logic [15:0]                 i_blue,
    input  logic [15:0]                 i_clear,
    output logic                        o_strobe,
    output logic [15:0]                 o_cct_kelvin,
    output logic [rgbct_pkg::LUX_W-1:0] o_lux_q4,
    output logic [1:0]                  o_status
);
    import rgbct_pkg::*;

    localparam int D2_LEN = DIV_LAT + 5;

    // quotient magnitude to saturated signed value
    function automatic logic signed [XY_W-1:0] sat_xy(
        input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
        logic signed [QUO_W:0] v;
        v = $signed({1'b0, q});
        if (!neg && (ovf || q > QUO_W'(XY_POS_LIM))) return XY_W'(XY_POS_LIM);
        if (neg && (ovf || q > QUO_W'(XY_NEG_LIM))) return XY_W'(-XY_NEG_LIM);
        return neg ? XY_W'(-v) : XY_W'(v);
    endfunction

    function automatic logic signed [N_W-1:0] sat_n(
        input logic [QUO_W-1:0] q, input logic ovf, input logic neg);
        logic signed [QUO_W:0] v;
        v = $signed({1'b0, q});
        if (!neg && (ovf || q > QUO_W'(N_POS_LIM))) return N_W'(N_POS_LIM);
        if (neg && (ovf || q > QUO_W'(N_NEG_LIM))) return N_W'(-N_NEG_LIM);
        return neg ? N_W'(-v) : N_W'(v);
    endfunction

    // stage 1: matrix products
    logic                     r_v1, r_cz1;
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [SMP_W-1:0]  s_smp [3];

    assign s_smp[0] = $signed({1'b0, i_red & SAMPLE_MASK});
    assign s_smp[1] = $signed({1'b0, i_green & SAMPLE_MASK});
    assign s_smp[2] = $signed({1'b0, i_blue & SAMPLE_MASK});
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_cz1 <= ((i_clear & SAMPLE_MASK) == 16'd0);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= PROD_W'(COEF[i][j]) * PROD_W'(s_smp[j]);
            end
        end
    end

    // stage 2: xyz rows
    logic                    r_v2, r_cz2;
    logic signed [ROW_W-1:0] r_row [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_cz2 <= r_cz1;
        for (int i = 0; i < 3; i++) begin
            r_row[i] <= ROW_W'(r_prod[i][0]) + ROW_W'(r_prod[i][1]) + ROW_W'(r_prod[i][2]);
        end
    end

    // stage 3: chromaticity sum, lux, divider operands
    logic signed [ROW_W-1:0] s_den, s_abs_x, s_abs_y, s_abs_d, s_lux_sh;
    logic [LUX_W-1:0]        s_lux;
    t_side                   r_side3;
    logic [NUM_W-1:0]        r_xnum, r_ynum;
    logic [DEN_W-1:0]        r_dmag;
    logic                    r_xneg, r_yneg;

    always_comb begin
        s_den    = r_row[0] + r_row[1] + r_row[2];
        s_abs_x  = r_row[0][ROW_W-1] ? -r_row[0] : r_row[0];
        s_abs_y  = r_row[1][ROW_W-1] ? -r_row[1] : r_row[1];
        s_abs_d  = s_den[ROW_W-1] ? -s_den : s_den;
        s_lux_sh = r_row[1] >>> (Q_FRAC - 4);
        s_lux    = '0;
        if (!r_cz2 && r_row[1] > 0) begin
            s_lux = (s_lux_sh > ROW_W'(LUX_MAX)) ? LUX_W'(LUX_MAX) : s_lux_sh[LUX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side3 <= '0;
        end else begin
            r_side3 <= '{valid: r_v2, clr_zero: r_cz2, den_zero: (s_den == '0), lux: s_lux};
        end
        r_xnum <= {s_abs_x[NUM_W-Q_FRAC-1:0], Q_FRAC'(0)};
        r_ynum <= {s_abs_y[NUM_W-Q_FRAC-1:0], Q_FRAC'(0)};
        r_dmag <= s_abs_d[DEN_W-1:0];
        r_xneg <= r_row[0][ROW_W-1] ^ s_den[ROW_W-1];
        r_yneg <= r_row[1][ROW_W-1] ^ s_den[ROW_W-1];
    end

    // x and y dividers, side data delayed alongside
    logic [QUO_W-1:0] w_xq, w_yq;
    logic             w_xovf, w_yovf, w_xneg, w_yneg;
    t_side            r_d1 [DIV_LAT];

    rgbct_div u_div_x (
        .i_clk (i_clk), .i_num (r_xnum), .i_den (r_dmag), .i_neg (r_xneg),
        .o_quo (w_xq), .o_ovf (w_xovf), .o_neg (w_xneg)
    );

    rgbct_div u_div_y (
        .i_clk (i_clk), .i_num (r_ynum), .i_den (r_dmag), .i_neg (r_yneg),
        .o_quo (w_yq), .o_ovf (w_yovf), .o_neg (w_yneg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_d1[k] <= '0;
            end
        end else begin
            r_d1[0] <= r_side3;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_d1[k] <= r_d1[k-1];
            end
        end
    end

    // stage 4: mccamy numerator and denominator
    logic signed [XY_W-1:0] s_xc, s_yc;
    logic signed [XY_W:0]   s_num, s_dn, s_abs_num, s_abs_dn;
    t_side                  r_side4;
    logic [NUM_W-1:0]       r_nnum;
    logic [DEN_W-1:0]       r_nden;
    logic                   r_nneg;

    always_comb begin
        s_xc      = sat_xy(w_xq, w_xovf, w_xneg);
        s_yc      = sat_xy(w_yq, w_yovf, w_yneg);
        s_num     = (XY_W + 1)'(s_xc) - X_REF;
        s_dn      = Y_REF - (XY_W + 1)'(s_yc);
        s_abs_num = s_num[XY_W] ? -s_num : s_num;
        s_abs_dn  = s_dn[XY_W] ? -s_dn : s_dn;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side4 <= '0;
        end else begin
            r_side4 <= '{valid: r_d1[DIV_LAT-1].valid,
                         clr_zero: r_d1[DIV_LAT-1].clr_zero,
                         den_zero: r_d1[DIV_LAT-1].den_zero || (s_dn == '0),
                         lux: r_d1[DIV_LAT-1].lux};
        end
        r_nnum <= NUM_W'({s_abs_num[XY_W-1:0], Q_FRAC'(0)});
        r_nden <= DEN_W'(s_abs_dn[XY_W-1:0]);
        r_nneg <= s_num[XY_W] ^ s_dn[XY_W];
    end

    // n divider
    logic [QUO_W-1:0] w_nq;
    logic             w_novf, w_nneg;
    t_side            r_d2 [D2_LEN];

    rgbct_div u_div_n (
        .i_clk (i_clk), .i_num (r_nnum), .i_den (r_nden), .i_neg (r_nneg),
        .o_quo (w_nq), .o_ovf (w_novf), .o_neg (w_nneg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < D2_LEN; k++) begin
                r_d2[k] <= '0;
            end
        end else begin
            r_d2[0] <= r_side4;
            for (int k = 1; k < D2_LEN; k++) begin
                r_d2[k] <= r_d2[k-1];
            end
        end
    end

    // stages 5 to 9: horner evaluation of the cubic, n delayed alongside
    logic signed [N_W-1:0]  r_n5, r_n6, r_n7, r_n8;
    logic signed [A_W-1:0]  r_a;
    logic signed [P1_W-1:0] r_p1;
    logic signed [BS_W-1:0] s_bs;
    logic signed [B_W-1:0]  r_b;
    logic signed [P2_W-1:0] r_p2;

    always_comb begin
        s_bs = BS_W'(r_p1 >>> Q_FRAC) + B_OFF;
    end

    always_ff @(posedge i_clk) begin
        r_n5 <= sat_n(w_nq, w_novf, w_nneg);
        r_a  <= A_W'(r_n5) * K_CUBE + A_OFF;
        r_n6 <= r_n5;
        r_p1 <= P1_W'(r_a) * P1_W'(r_n6);
        r_n7 <= r_n6;
        if (s_bs > B_LIM) begin
            r_b <= B_W'(B_LIM);
        end else if (s_bs < -B_LIM) begin
            r_b <= B_W'(-B_LIM);
        end else begin
            r_b <= B_W'(s_bs);
        end
        r_n8 <= r_n7;
        r_p2 <= P2_W'(r_b) * P2_W'(r_n8);
    end

    // output stage: final add, truncation, saturation, special cases
    t_side                 s_side;
    logic signed [C_W-1:0] s_c, s_ck;
    logic [15:0]           s_cct;
    t_status               s_status;
    logic                  r_strobe;
    logic [15:0]           r_cct;
    logic [LUX_W-1:0]      r_lux;
    t_status               r_status;

    always_comb begin
        s_side   = r_d2[D2_LEN-1];
        s_c      = C_W'(r_p2 >>> Q_FRAC) + C_OFF;
        s_ck     = s_c >>> Q_FRAC;
        s_cct    = '0;
        s_status = ST_OK;
        priority if (s_c <= -(C_W'(1) <<< Q_FRAC)) begin
            s_status = ST_CCT_SAT;
        end else if (s_c < 0) begin
            s_cct = '0;
        end else if (s_ck > C_W'(16'hffff)) begin
            s_cct    = 16'hffff;
            s_status = ST_CCT_SAT;
        end else begin
            s_cct = s_ck[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= s_side.valid;
        end
        priority if (s_side.clr_zero) begin
            r_cct    <= '0;
            r_lux    <= '0;
            r_status <= ST_CLEAR_ZERO;
        end else if (s_side.den_zero) begin
            r_cct    <= '0;
            r_lux    <= s_side.lux;
            r_status <= ST_ZERO_DEN;
        end else begin
            r_cct    <= s_cct;
            r_lux    <= s_side.lux;
            r_status <= s_status;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_cct_kelvin = r_cct;
    assign o_lux_q4     = r_lux;
    assign o_status     = r_status;

    `RGBCT_ASSERT_SAME(a_clear_zero_out, i_clk, i_rst_n, o_strobe && o_status == ST_CLEAR_ZERO, o_cct_kelvin == 16'd0 && o_lux_q4 == '0)
    `RGBCT_ASSERT_SAME(a_zero_den_cct, i_clk, i_rst_n, o_strobe && o_status == ST_ZERO_DEN, o_cct_kelvin == 16'd0)
    `RGBCT_ASSERT_SAME(a_sat_rails, i_clk, i_rst_n, o_strobe && o_status == ST_CCT_SAT, o_cct_kelvin == 16'd0 || o_cct_kelvin == 16'hffff)
    `RGBCT_ASSERT_SAME(a_strobe_has_request, i_clk, i_rst_n, o_strobe, $past(start && !busy, PIPE_DEPTH))

endmodule

/* test/rgb_colour_temperature_and_lux_checker.sv */
// checker: predicts cct, lux and status for each request and compares results
`timescale 1ns / 1ps
module rgb_colour_temperature_and_lux_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic                        busy,
    input  logic [15:0]                 i_red,
    input  logic [15:0]                 i_green,
    input  logic [15:0]                 i_blue,
    input  logic [15:0]                 i_clear,
    input  logic                        o_strobe,
    input  logic [15:0]                 o_cct_kelvin,
    input  logic [rgbct_pkg::LUX_W-1:0] o_lux_q4,
    input  logic [1:0]                  o_status,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_status_seen [4]
);
    import rgbct_pkg::*;

    typedef struct packed {
        logic [15:0]      cct;
        logic [LUX_W-1:0] lux;
        t_status          st;
    } t_reading;

    t_reading readings_due [$];

    function automatic longint floor16(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clampl(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic t_reading light_reading(logic [15:0] r, logic [15:0] g,
                                               logic [15:0] b, logic [15:0] c);
        longint rw [3];
        longint sm [3];
        longint den, xc, yc, dn, n, a, bb, cc;
        t_reading res;
        res = '{cct: '0, lux: '0, st: ST_OK};
        sm[0] = longint'(r & SAMPLE_MASK);
        sm[1] = longint'(g & SAMPLE_MASK);
        sm[2] = longint'(b & SAMPLE_MASK);
        if ((c & SAMPLE_MASK) == 0) begin
            res.st = ST_CLEAR_ZERO;
            return res;
        end
        for (int i = 0; i < 3; i++) begin
            rw[i] = 0;
            for (int j = 0; j < 3; j++) rw[i] += longint'(COEF[i][j]) * sm[j];
        end
        if (rw[1] > 0) res.lux = LUX_W'(clampl(floor16(rw[1] * 16), 0, LUX_MAX));
        den = rw[0] + rw[1] + rw[2];
        if (den == 0) begin
            res.st = ST_ZERO_DEN;
            return res;
        end
        // division truncates toward zero, as in the hardware divider
        xc = clampl((rw[0] * 65536) / den, -131072, 131071);
        yc = clampl((rw[1] * 65536) / den, -131072, 131071);
        dn = 12177 - yc;
        if (dn == 0) begin
            res.st = ST_ZERO_DEN;
            return res;
        end
        n = clampl(((xc - 21758) * 65536) / dn, -16777216, 16777215);
        a = 449 * n + 64'sd3525 * 65536;
        bb = clampl(floor16(a * n) + 447171789, -(64'sd1 << 38), 64'sd1 << 38);
        cc = floor16(bb * n) + 361780347;
        if (cc <= -65536) res.st = ST_CCT_SAT;
        else if (cc >= 0) begin
            if (floor16(cc) > 65535) begin
                res.cct = 16'hffff;
                res.st = ST_CCT_SAT;
            end else res.cct = 16'(floor16(cc));
        end
        return res;
    endfunction

    assign o_pending = readings_due.size();

    always @(posedge i_clk) begin
        t_reading exp_r;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            for (int k = 0; k < 4; k++) o_status_seen[k] <= 0;
        end else begin
            if (o_strobe) begin
                if (readings_due.size() == 0) begin
                    $display("%0t: result with none expected: cct %0d lux %0d st %0d",
                             $time, o_cct_kelvin, o_lux_q4, o_status);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = readings_due.pop_front();
                    o_status_seen[o_status] <= o_status_seen[o_status] + 1;
                    if (o_cct_kelvin !== exp_r.cct || o_lux_q4 !== exp_r.lux
                        || o_status !== exp_r.st) begin
                        $display("%0t: mismatch exp cct %0d lux %0d st %0d, got %0d %0d %0d",
                                 $time, exp_r.cct, exp_r.lux, exp_r.st,
                                 o_cct_kelvin, o_lux_q4, o_status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                readings_due.push_back(light_reading(i_red, i_green, i_blue, i_clear));
        end
    end
endmodule

/* test/rgb_colour_temperature_and_lux_tb.sv */
// testbench top: sample stimulus, reset, watchdog and verdict
`timescale 1ns / 1ps
module rgb_colour_temperature_and_lux_tb;
    import rgbct_pkg::*;

    localparam int N_RANDOM = 900;
    // longest gap is the top of the pick_gap range, pipeline is about 62 deep
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 2 * PIPE_DEPTH;

    logic i_clk, i_rst_n, start, busy, o_strobe;
    logic [15:0] i_red, i_green, i_blue, i_clear, o_cct_kelvin;
    logic [LUX_W-1:0] o_lux_q4;
    logic [1:0] o_status;
    int fail_count, pending, idle_cycles, sent;
    int status_seen [4];

    rgb_colour_temperature_and_lux dut (.*);
    rgb_colour_temperature_and_lux_checker u_checker (
        .*, .o_fail_count(fail_count), .o_pending(pending),
        .o_status_seen(status_seen));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: cycles in which neither a request nor a result is taken
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // hold one request until taken, then drop start only when the next gap begins
    task automatic send_sample(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                               logic [15:0] c, int gap);
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        i_clear <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_count();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] base;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_red = '0;
        i_green = '0;
        i_blue = '0;
        i_clear = '0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: clear zero, all-zero sample, extremes, grey, primaries
        send_sample(16'h1234, 16'h5678, 16'h9abc, 16'h0000, 0);
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0001, 0);
        send_sample(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1);
        send_sample(16'hffff, 16'h0000, 16'h0000, 16'hffff, 0);
        send_sample(16'h0000, 16'hffff, 16'h0000, 16'hffff, 2);
        send_sample(16'h0000, 16'h0000, 16'hffff, 16'hffff, 0);
        send_sample(16'hffff, 16'hffff, 16'h0000, 16'h8000, 0);
        send_sample(16'h0000, 16'hffff, 16'hffff, 16'h8000, 3);
        send_sample(16'hffff, 16'h0000, 16'hffff, 16'h8000, 0);
        send_sample(16'd1000, 16'd1000, 16'd1000, 16'd3000, 0);
        send_sample(16'd1, 16'd0, 16'd0, 16'd1, 0);
        send_sample(16'd0, 16'd1, 16'd0, 16'd1, 0);
        send_sample(16'd0, 16'd0, 16'd1, 16'd1, 20);
        send_sample(16'd4000, 16'd3000, 16'd1500, 16'd9000, 0);
        send_sample(16'd1500, 16'd3000, 16'd4500, 16'd9000, 0);
        send_sample(16'd6000, 16'd2000, 16'd500, 16'd9000, 0);

        // random: mostly plausible light (channels near a common level), some raw noise
        for (int k = 0; k < N_RANDOM; k++) begin
            if ($urandom_range(0, 3) != 0) begin
                base = 16'($urandom_range(1, 60000));
                send_sample(16'(base + $urandom_range(0, 5000)),
                            16'(base + $urandom_range(0, 5000)),
                            16'(base + $urandom_range(0, 5000)),
                            16'($urandom_range(0, 20) == 0 ? 0 : $urandom),
                            pick_gap());
            end else
                send_sample(pick_count(), pick_count(), pick_count(), pick_count(),
                            pick_gap());
        end
        start <= 1'b0;
        @(posedge i_clk);

        while (pending > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("run: %0d samples sent; status ok %0d, clear zero %0d, zero den %0d, sat %0d",
                 sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
